>>> src/mteq_pkg.sv
package mteq_pkg;

    // Field widths of one stored event.
    localparam int ID_W     = 16;
    localparam int PRIO_W   = 4;
    localparam int MOMENT_W = 32;
    localparam int STATUS_W = 3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADPRIO  = 3'd4;

    // One event as held in a cell.
    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [PRIO_W-1:0]   prio;
        logic [MOMENT_W-1:0] moment;
    } entry_t;

    // Per-cycle control broadcast to every cell of the chain.
    typedef struct packed {
        logic ins_en;
        logic rem_en;
    } chain_ctrl_t;

    // True when event a must stand before event b in the store.
    function automatic logic goes_before(entry_t a, entry_t b);
        logic res;
        if (a.prio != b.prio)
        begin
            res = (a.prio > b.prio);
        end
        else
        begin
            res = (a.moment < b.moment);
        end
        return res;
    endfunction

endpackage

>>> src/mteq_cell.sv
module mteq_cell
    import mteq_pkg::*;
(
    input  logic        clk,
    input  chain_ctrl_t ctrl,
    input  logic        occupied,
    input  entry_t      new_entry,
    input  entry_t      left_entry,
    input  logic        left_before,
    input  entry_t      right_entry,
    output entry_t      entry,
    output logic        fits_here
);

    entry_t entry_reg;
    entry_t entry_next;

    // The new event belongs at or ahead of this cell; an empty cell always qualifies.
    assign fits_here = !occupied || goes_before(new_entry, entry_reg);

    // Insert: the first qualifying cell takes the new event, the ones after it
    // take their left neighbor. Remove: each cell but the last takes its right neighbor.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins_en && fits_here)
        begin
            entry_next = left_before ? left_entry : new_entry;
        end
        else if (ctrl.rem_en)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> src/multilevel_timed_event_queue_top.sv
// Channel  | Direction | Handshake              | Payload
// request  | in        | start high, busy low   | opcode, event_id, priority_req, moment
// result   | out       | done strobe, one cycle | status, out_id, out_priority, out_moment,
//          |           |                        | occupancy
//
// A request is taken when start is high, and its result shows on done in the next cycle.
// busy stays low: every cell of the sorted chain compares and shifts in the same
// cycle, so a new request can follow each cycle.
// Reset clears the event count and the result strobe; cell contents stay undefined.
// The receiver cannot stall; each result is valid for exactly one cycle.
module multilevel_timed_event_queue_top
    import mteq_pkg::*;
#(
    parameter int LEVELS   = 8,
    parameter int CAPACITY = 64,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                opcode,
    input  logic [ID_W-1:0]     event_id,
    input  logic [PRIO_W-1:0]   priority_req,
    input  logic [MOMENT_W-1:0] moment,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]     out_id,
    output logic [PRIO_W-1:0]   out_priority,
    output logic [MOMENT_W-1:0] out_moment,
    output logic [CNT_W-1:0]    occupancy
);

    localparam logic [PRIO_W:0]  LEVELS_TOP = (PRIO_W + 1)'(LEVELS);
    localparam logic [CNT_W-1:0] CAP_CNT    = CNT_W'(CAPACITY);

    logic                count_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    entry_t              out_reg;
    entry_t              out_next;

    logic        accept;
    logic        bad_prio;
    logic        full;
    logic        empty;
    chain_ctrl_t ctrl;
    entry_t      new_entry;
    entry_t      cell_q [CAPACITY];
    logic        cell_before [CAPACITY];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Request decode.
    assign new_entry.id     = event_id;
    assign new_entry.prio   = priority_req;
    assign new_entry.moment = moment;
    assign bad_prio = (priority_req == '0) || ({1'b0, priority_req} > LEVELS_TOP);
    assign full     = (cnt_reg == CAP_CNT);
    assign empty    = (cnt_reg == '0);
    assign ctrl.ins_en = accept && !opcode && !bad_prio && !full;
    assign ctrl.rem_en = accept && opcode && !empty;

    // The sorted chain of cells.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t left_e;
        logic   left_b;
        entry_t right_e;
        if (i == 0)
        begin : g_head
            assign left_e = new_entry;
            assign left_b = 1'b0;
        end
        else
        begin : g_body
            assign left_e = cell_q[i-1];
            assign left_b = cell_before[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_e = cell_q[i];
        end
        else
        begin : g_mid
            assign right_e = cell_q[i+1];
        end
        mteq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (cnt_reg > CNT_W'(i)),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .left_before (left_b),
            .right_entry (right_e),
            .entry       (cell_q[i]),
            .fits_here   (cell_before[i])
        );
    end

    // Count update and result formation.
    always_comb
    begin
        cnt_next    = cnt_reg;
        status_next = ST_INSERTED;
        out_next    = '0;
        if (!opcode)
        begin
            if (bad_prio)
            begin
                status_next = ST_BADPRIO;
            end
            else if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_INSERTED;
                cnt_next    = cnt_reg + 1'b1;
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                status_next = ST_REMOVED;
                out_next    = cell_q[0];
                cnt_next    = cnt_reg - 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            count_reg <= 1'b0;
        end
        else
        begin
            done_reg  <= accept;
            count_reg <= 1'b1;
            if (accept)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            out_reg    <= out_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign out_id       = out_reg.id;
    assign out_priority = out_reg.prio;
    assign out_moment   = out_reg.moment;
    assign occupancy    = cnt_reg;

`ifndef ASSERT_OFF
    // Every transfer in gives exactly one result the next cycle.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result strobe missing after request transfer");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result strobe without request transfer");

    // The count never runs past the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CAP_CNT)
        else $error("event count above capacity");

    // A removed event carries a valid priority.
    a_removed_prio: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_REMOVED) |->
            (out_priority != '0) && ({1'b0, out_priority} <= LEVELS_TOP))
        else $error("removed event with invalid priority");

    // The head of the chain is never out of order with its successor.
    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg && cnt_reg >= CNT_W'(2)) |-> !goes_before(cell_q[1], cell_q[0]))
        else $error("chain head out of order");
`endif

endmodule
